### hdl/sbq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbq_pkg - stereo biquad shared definitions
// Field widths, register indexes, control word layout and the microcode ROM.
// ----------------------------------------------------------------------------
package sbq_pkg;

  localparam int unsigned DEF_SAMPLE_BITS    = 24;
  localparam int unsigned DEF_COEF_FRAC_BITS = 20;
  localparam int unsigned DEF_NUM_CHANNELS   = 2;

  localparam int unsigned COEF_W     = 24;
  localparam int unsigned GAIN_W     = 17;
  localparam int unsigned GAIN_FRAC  = 16;
  localparam int unsigned NUM_TAPS   = 5;
  localparam int unsigned MUL_B_W    = COEF_W + 1;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned PC_W       = 4;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0     = 3'd0,
    REG_B1     = 3'd1,
    REG_B2     = 3'd2,
    REG_F1     = 3'd3,
    REG_F2     = 3'd4,
    REG_GAIN   = 3'd5,
    REG_BYPASS = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [NUM_TAPS-1:0][COEF_W-1:0] coef;
    logic [GAIN_W-1:0]               gain;
    logic                            bypass;
  } cfg_t;

  // multiplier operand pair
  typedef enum logic [2:0] {
    MUL_B0_X  = 3'd0,
    MUL_B1_X1 = 3'd1,
    MUL_B2_X2 = 3'd2,
    MUL_F1_Y1 = 3'd3,
    MUL_F2_Y2 = 3'd4,
    MUL_G_Y   = 3'd5
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD    = 2'd0,
    ACC_LOAD_RF = 2'd1,
    ACC_ADD     = 2'd2,
    ACC_LOAD_RG = 2'd3
  } acc_op_e;

  typedef enum logic [1:0] {
    OUT_NONE   = 2'd0,
    OUT_GAIN   = 2'd1,
    OUT_BYPASS = 2'd2
  } out_op_e;

  typedef enum logic [1:0] {
    JMP_NEXT   = 2'd0,
    JMP_BYPASS = 2'd1,
    JMP_END    = 2'd2
  } jmp_e;

  typedef struct packed {
    mul_sel_e        mul_sel;
    acc_op_e         acc_op;
    logic            wr_hist;
    out_op_e         out_op;
    jmp_e            jmp;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic bypass;
    logic out_stall;
  } status_t;

  localparam logic [PC_W-1:0] STEP_BYPASS = PC_W'(10);

  localparam ucode_t UC_NOP = '{
    mul_sel: MUL_B0_X, acc_op: ACC_HOLD, wr_hist: 1'b0,
    out_op: OUT_NONE, jmp: JMP_NEXT, target: '0
  };

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] step);
    ucode_t uc;
    uc = UC_NOP;
    case (step)
      PC_W'(0): begin
        uc.mul_sel = MUL_B0_X;
        uc.jmp     = JMP_BYPASS;
        uc.target  = STEP_BYPASS;
      end
      PC_W'(1): begin
        uc.mul_sel = MUL_B1_X1;
        uc.acc_op  = ACC_LOAD_RF;
      end
      PC_W'(2): begin
        uc.mul_sel = MUL_B2_X2;
        uc.acc_op  = ACC_ADD;
      end
      PC_W'(3): begin
        uc.mul_sel = MUL_F1_Y1;
        uc.acc_op  = ACC_ADD;
      end
      PC_W'(4): begin
        uc.mul_sel = MUL_F2_Y2;
        uc.acc_op  = ACC_ADD;
      end
      PC_W'(5): begin
        uc.acc_op = ACC_ADD;
      end
      PC_W'(6): begin
        uc.wr_hist = 1'b1;
      end
      PC_W'(7): begin
        uc.mul_sel = MUL_G_Y;
      end
      PC_W'(8): begin
        uc.acc_op = ACC_LOAD_RG;
      end
      PC_W'(9): begin
        uc.out_op = OUT_GAIN;
        uc.jmp    = JMP_END;
      end
      STEP_BYPASS: begin
        uc.out_op = OUT_BYPASS;
        uc.jmp    = JMP_END;
      end
      default: begin
        uc     = UC_NOP;
        uc.jmp = JMP_END;
      end
    endcase
    return uc;
  endfunction

endpackage

### hdl/sbq_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbq_in_if - sample input channel
// Valid/ready channel carrying one tagged sample.
// ----------------------------------------------------------------------------
interface sbq_in_if #(
  parameter int unsigned SAMPLE_BITS = 24
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_in;
  logic                   channel;
  logic                   block_end;

  modport source (output valid, output sample_in, output channel, output block_end,
                  input ready);
  modport sink   (input valid, input sample_in, input channel, input block_end,
                  output ready);
endinterface

### hdl/sbq_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbq_out_if - sample output channel
// Valid/ready channel carrying one filtered or bypassed sample.
// ----------------------------------------------------------------------------
interface sbq_out_if #(
  parameter int unsigned SAMPLE_BITS = 24
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_out;
  logic                   channel_out;
  logic                   block_end_out;

  modport source (output valid, output sample_out, output channel_out,
                  output block_end_out, input ready);
  modport sink   (input valid, input sample_out, input channel_out,
                  input block_end_out, output ready);
endinterface

### hdl/sbq_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbq_cfg_if - configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface sbq_cfg_if;
  import sbq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/sbq_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbq_cfg_regs - configuration register file
// Coefficients, output gain and bypass, written one register per transaction.
// ----------------------------------------------------------------------------
module sbq_cfg_regs import sbq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [CFG_IDX_W-1:0]  wr_idx_i,
  input  logic [CFG_DATA_W-1:0] wr_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_idx_i)
        REG_B0:     cfg_d.coef[0] = wr_data_i[COEF_W-1:0];
        REG_B1:     cfg_d.coef[1] = wr_data_i[COEF_W-1:0];
        REG_B2:     cfg_d.coef[2] = wr_data_i[COEF_W-1:0];
        REG_F1:     cfg_d.coef[3] = wr_data_i[COEF_W-1:0];
        REG_F2:     cfg_d.coef[4] = wr_data_i[COEF_W-1:0];
        REG_GAIN:   cfg_d.gain    = wr_data_i[GAIN_W-1:0];
        REG_BYPASS: cfg_d.bypass  = wr_data_i[0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef   <= '0;
      cfg_q.gain   <= GAIN_RESET;
      cfg_q.bypass <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/sbq_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbq_sequencer - microcode sequencer
// Step counter over the control ROM with bypass branch and output stall.
// ----------------------------------------------------------------------------
module sbq_sequencer import sbq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  status_t status_i,
  output logic    busy_o,
  output ucode_t  ctrl_o,
  output logic    advance_o
);

  logic            busy_q, busy_d;
  logic [PC_W-1:0] pc_q, pc_d;
  ucode_t          uc;
  logic            advance;

  assign uc = ucode_rom(pc_q);

  // an output step waits while the result register is still full and out_chan is not ready
  assign advance = busy_q && !((uc.out_op != OUT_NONE) && status_i.out_stall);

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        pc_d   = '0;
      end
    end else if (advance) begin
      case (uc.jmp)
        JMP_NEXT:   pc_d = pc_q + PC_W'(1);
        JMP_BYPASS: pc_d = status_i.bypass ? uc.target : pc_q + PC_W'(1);
        JMP_END:    busy_d = 1'b0;
        default:    busy_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  assign busy_o    = busy_q;
  assign ctrl_o    = busy_q ? uc : UC_NOP;
  assign advance_o = advance;

endmodule

### hdl/sbq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbq_datapath - shared multiply-accumulate datapath
// One multiplier, accumulator with rounding, saturation, per-channel history
// and the output register.
// ----------------------------------------------------------------------------
module sbq_datapath import sbq_pkg::*; #(
  parameter int unsigned SAMPLE_BITS    = DEF_SAMPLE_BITS,
  parameter int unsigned COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
  parameter int unsigned NUM_CHANNELS   = DEF_NUM_CHANNELS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   channel_i,
  input  logic                   block_end_i,
  input  cfg_t                   cfg_i,
  input  ucode_t                 ctrl_i,
  input  logic                   advance_i,
  output status_t                status_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SAMPLE_BITS-1:0] sample_o,
  output logic                   channel_o,
  output logic                   block_end_o
);

  localparam int unsigned CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned PROD_W = SAMPLE_BITS + MUL_B_W;
  localparam int unsigned ACC_W  = PROD_W + 3;

  localparam logic signed [ACC_W-1:0] RND_F = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] RND_G = ACC_W'(1) << (GAIN_FRAC - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  logic signed [SAMPLE_BITS-1:0] x_q, y_q;
  logic                          ch_q, be_q;
  logic [CH_W-1:0]               ch_sel_q;

  logic signed [SAMPLE_BITS-1:0] prev_in_q   [NUM_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] prev_in2_q  [NUM_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] prev_out_q  [NUM_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] prev_out2_q [NUM_CHANNELS];

  logic signed [SAMPLE_BITS-1:0] op_a;
  logic signed [MUL_B_W-1:0]     op_b;
  logic signed [PROD_W-1:0]      prod_q;
  logic signed [ACC_W-1:0]       acc_q, acc_d;
  logic signed [ACC_W-1:0]       shifted;
  logic signed [SAMPLE_BITS-1:0] sat_val;

  logic                          out_valid_q;
  logic [SAMPLE_BITS-1:0]        sample_out_q;
  logic                          ch_out_q, be_out_q;
  logic                          out_load, out_stall;

  // input capture; a channel past the last history set uses the last one
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      x_q  <= sample_i;
      ch_q <= channel_i;
      be_q <= block_end_i;
      if (int'(channel_i) >= int'(NUM_CHANNELS)) begin
        ch_sel_q <= CH_W'(NUM_CHANNELS - 1);
      end else begin
        ch_sel_q <= CH_W'(channel_i);
      end
    end
  end

  always_comb begin
    op_a = x_q;
    op_b = MUL_B_W'($signed(cfg_i.coef[0]));
    case (ctrl_i.mul_sel)
      MUL_B0_X: begin
        op_a = x_q;
        op_b = MUL_B_W'($signed(cfg_i.coef[0]));
      end
      MUL_B1_X1: begin
        op_a = prev_in_q[ch_sel_q];
        op_b = MUL_B_W'($signed(cfg_i.coef[1]));
      end
      MUL_B2_X2: begin
        op_a = prev_in2_q[ch_sel_q];
        op_b = MUL_B_W'($signed(cfg_i.coef[2]));
      end
      MUL_F1_Y1: begin
        op_a = prev_out_q[ch_sel_q];
        op_b = MUL_B_W'($signed(cfg_i.coef[3]));
      end
      MUL_F2_Y2: begin
        op_a = prev_out2_q[ch_sel_q];
        op_b = MUL_B_W'($signed(cfg_i.coef[4]));
      end
      MUL_G_Y: begin
        op_a = y_q;
        op_b = $signed({{(MUL_B_W-GAIN_W){1'b0}}, cfg_i.gain});
      end
      default: begin
        op_a = x_q;
        op_b = MUL_B_W'($signed(cfg_i.coef[0]));
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
  end

  always_comb begin
    case (ctrl_i.acc_op)
      ACC_HOLD:    acc_d = acc_q;
      ACC_LOAD_RF: acc_d = ACC_W'(prod_q) + RND_F;
      ACC_ADD:     acc_d = acc_q + ACC_W'(prod_q);
      ACC_LOAD_RG: acc_d = ACC_W'(prod_q) + RND_G;
      default:     acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // rounding constant is already in the accumulator, so the shift floors
  assign shifted = (ctrl_i.out_op == OUT_GAIN) ? (acc_q >>> GAIN_FRAC)
                                                : (acc_q >>> COEF_FRAC_BITS);

  always_comb begin
    if (shifted > SAT_HI) begin
      sat_val = SAT_HI[SAMPLE_BITS-1:0];
    end else if (shifted < SAT_LO) begin
      sat_val = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      sat_val = shifted[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_hist) begin
      y_q <= sat_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(NUM_CHANNELS); i++) begin
        prev_in_q[i]   <= '0;
        prev_in2_q[i]  <= '0;
        prev_out_q[i]  <= '0;
        prev_out2_q[i] <= '0;
      end
    end else if (ctrl_i.wr_hist) begin
      prev_in2_q[ch_sel_q]  <= prev_in_q[ch_sel_q];
      prev_in_q[ch_sel_q]   <= x_q;
      prev_out2_q[ch_sel_q] <= prev_out_q[ch_sel_q];
      prev_out_q[ch_sel_q]  <= sat_val;
    end
  end

  assign out_stall = out_valid_q && !out_ready_i;
  assign out_load  = advance_i && (ctrl_i.out_op != OUT_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sample_out_q <= (ctrl_i.out_op == OUT_BYPASS) ? x_q : sat_val;
      ch_out_q     <= ch_q;
      be_out_q     <= be_q;
    end
  end

  assign status_o.bypass    = cfg_i.bypass;
  assign status_o.out_stall = out_stall;

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_out_q;
  assign channel_o   = ch_out_q;
  assign block_end_o = be_out_q;

endmodule

### hdl/stereo_biquad_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_biquad_filter_unit - two-channel direct-form-I biquad
// Microcoded multiply-accumulate biquad with output gain and bypass.
// ----------------------------------------------------------------------------
//  port      dir  transaction carries
//  in_chan   in   sample_in, channel, block_end
//  out_chan  out  sample_out, channel_out, block_end_out
//  cfg_chan  in   index, data (coefficients, gain, bypass)
//
//  a filtered sample is accepted and then runs ten microcode steps through the
//  one shared multiplier (five taps, gain) before the next one is taken; in
//  bypass the first step branches straight to the output step
//  in_chan.ready is high whenever the sequencer is idle, also while a result
//  waits in the output register; only the output step stalls on out_chan
//  reset clears history, coefficients and bypass, sets the gain to one
// ----------------------------------------------------------------------------
module stereo_biquad_filter_unit import sbq_pkg::*; #(
  parameter int unsigned SAMPLE_BITS    = DEF_SAMPLE_BITS,
  parameter int unsigned COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
  parameter int unsigned NUM_CHANNELS   = DEF_NUM_CHANNELS
) (
  input logic       clk_i,
  input logic       rst_ni,
  sbq_in_if.sink    in_chan,
  sbq_out_if.source out_chan,
  sbq_cfg_if.sink   cfg_chan
);

  cfg_t    cfg;
  ucode_t  ctrl;
  status_t status;
  logic    busy;
  logic    advance;
  logic    in_accept;

  assign in_chan.ready  = !busy;
  assign in_accept      = in_chan.valid && !busy;
  assign cfg_chan.ready = 1'b1;

  sbq_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_chan.valid),
    .wr_idx_i  (cfg_chan.index),
    .wr_data_i (cfg_chan.data),
    .cfg_o     (cfg)
  );

  sbq_sequencer u_sequencer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_accept),
    .status_i  (status),
    .busy_o    (busy),
    .ctrl_o    (ctrl),
    .advance_o (advance)
  );

  sbq_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .NUM_CHANNELS   (NUM_CHANNELS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .sample_i    (in_chan.sample_in),
    .channel_i   (in_chan.channel),
    .block_end_i (in_chan.block_end),
    .cfg_i       (cfg),
    .ctrl_i      (ctrl),
    .advance_i   (advance),
    .status_o    (status),
    .out_valid_o (out_chan.valid),
    .out_ready_i (out_chan.ready),
    .sample_o    (out_chan.sample_out),
    .channel_o   (out_chan.channel_out),
    .block_end_o (out_chan.block_end_out)
  );

endmodule
